FILE: rtl/core/tacp_pkg.sv
// tacp_pkg: shared types, character codes, kind codes and decimal constants
// for the typed ascii cell parser
// no dependencies
package tacp_pkg;

  typedef logic [1:0]         kind_t;
  typedef logic [4:0]         scale_t;
  typedef logic [4:0]         pos_t;
  typedef logic signed [63:0] value_t;

  localparam kind_t KIND_INT32 = 2'd0;
  localparam kind_t KIND_INT64 = 2'd1;
  localparam kind_t KIND_DATE  = 2'd2;
  localparam kind_t KIND_DEC64 = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_POINT = 8'h2e;

  localparam pos_t POS_MAX    = 5'd31;
  localparam pos_t DATE_LEN   = 5'd10;
  localparam pos_t DATE_SEP_A = 5'd4;
  localparam pos_t DATE_SEP_B = 5'd7;

  // first power of ten that no longer fits in 64 bits
  localparam scale_t POW10_TOP = 5'd20;

  localparam logic [63:0] LIM_I32_POS = 64'h0000_0000_7fff_ffff;
  localparam logic [63:0] LIM_I32_NEG = 64'h0000_0000_8000_0000;
  localparam logic [63:0] LIM_I64_POS = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] LIM_I64_NEG = 64'h8000_0000_0000_0000;

  function automatic logic [63:0] pow10(input scale_t e);
    logic [63:0] r;
    unique case (e)
      5'd0:  r = 64'd1;
      5'd1:  r = 64'd10;
      5'd2:  r = 64'd100;
      5'd3:  r = 64'd1000;
      5'd4:  r = 64'd10000;
      5'd5:  r = 64'd100000;
      5'd6:  r = 64'd1000000;
      5'd7:  r = 64'd10000000;
      5'd8:  r = 64'd100000000;
      5'd9:  r = 64'd1000000000;
      5'd10: r = 64'd10000000000;
      5'd11: r = 64'd100000000000;
      5'd12: r = 64'd1000000000000;
      5'd13: r = 64'd10000000000000;
      5'd14: r = 64'd100000000000000;
      5'd15: r = 64'd1000000000000000;
      5'd16: r = 64'd10000000000000000;
      5'd17: r = 64'd100000000000000000;
      5'd18: r = 64'd1000000000000000000;
      5'd19: r = 64'd10000000000000000000;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/tacp_char_if.sv
// tacp_char_if: character channel, one word per character of a cell string
// depends on tacp_pkg
interface tacp_char_if;
  logic              valid;
  logic              ready;
  logic [7:0]        char_byte;
  tacp_pkg::kind_t   kind;
  tacp_pkg::scale_t  scale;
  logic              last;
  logic              empty_req;

  modport source (output valid, char_byte, kind, scale, last, empty_req, input ready);
  modport sink   (input valid, char_byte, kind, scale, last, empty_req, output ready);
endinterface

FILE: rtl/core/tacp_result_if.sv
// tacp_result_if: result channel, one word per parsed cell
// depends on tacp_pkg
interface tacp_result_if;
  logic              valid;
  logic              ready;
  tacp_pkg::value_t  value;
  logic              ok;

  modport source (output valid, value, ok, input ready);
  modport sink   (input valid, value, ok, output ready);
endinterface

FILE: rtl/core/typed_ascii_cell_parser_top.sv
// typed_ascii_cell_parser_top: parses ascii cell strings into 64-bit values
// depends on tacp_pkg, tacp_char_if, tacp_result_if
//
// usage
//   chars takes one word per character; kind and scale are sampled on the
//   first word of a string, last closes it, empty_req sends an empty string
//   results gives one word (value, ok) for each word with last or empty_req
//   set; value is zero whenever ok is low
//   a word is taken when valid and ready are both high on a rising edge
// timing
//   three register stages: input word, snapshot, result
//   a closing word passes from the input stage via the snapshot stage to results
//   one character per cycle sustained outside stalls; the accumulator step
//   (times ten plus digit times a power of ten) sets the cycle time
// reset
//   rst is synchronous, active high; it empties all stages and clears the
//   string state, so the next word opens a new string
// stall
//   while results is held, words keep flowing until a closing word needs the
//   full snapshot stage; then chars.ready drops until the result is taken
module typed_ascii_cell_parser_top (
  input  logic                  clk,
  input  logic                  rst,
  tacp_char_if.sink             chars,
  tacp_result_if.source         results
);

  // input stage
  logic                  a_valid;
  logic [7:0]            a_char;
  tacp_pkg::kind_t       a_kind;
  tacp_pkg::scale_t      a_scale;
  logic                  a_last;
  logic                  a_empty;

  // string state; acc holds the digits already padded to the scale
  logic [63:0]           acc;
  tacp_pkg::scale_t      rem;
  tacp_pkg::pos_t        pos;
  logic                  seen_point;
  logic                  any_digit;
  logic                  negative;
  logic                  failed;
  tacp_pkg::kind_t       held_kind;

  // snapshot stage
  logic                  b_valid;
  logic [63:0]           b_acc;
  logic                  b_neg;
  logic                  b_fail;
  logic                  b_wide;

  // result stage
  logic                  o_valid;
  tacp_pkg::value_t      o_value;
  logic                  o_ok;

  logic                  o_free;
  logic                  b_adv;
  logic                  b_free;
  logic                  a_res;
  logic                  a_adv;

  tacp_pkg::kind_t       kind_eff;
  tacp_pkg::scale_t      rem_eff;
  logic                  is_digit;
  logic [3:0]            dig;
  logic                  frac_dig;
  tacp_pkg::scale_t      expo;
  logic [63:0]           pw;
  logic [67:0]           term;
  logic [68:0]           base;
  logic [68:0]           sum;
  logic                  push_ovf;
  logic                  push;

  logic [63:0]           acc_next;
  tacp_pkg::scale_t      rem_next;
  tacp_pkg::pos_t        pos_next;
  logic                  seen_point_next;
  logic                  any_digit_next;
  logic                  negative_next;
  logic                  failed_next;
  logic                  fin_fail;

  logic [63:0]           lim;
  logic                  ok_calc;

  assign o_free      = !o_valid || results.ready;
  assign b_adv       = b_valid && o_free;
  assign b_free      = !b_valid || b_adv;
  assign a_res       = a_last || a_empty;
  assign a_adv       = a_valid && (!a_res || b_free);
  assign chars.ready = !a_valid || a_adv;

  assign results.valid = o_valid;
  assign results.value = o_value;
  assign results.ok    = o_ok;

  always_comb begin
    kind_eff = (pos == '0) ? a_kind : held_kind;
    rem_eff  = (pos == '0) ? a_scale : rem;
    is_digit = (a_char >= tacp_pkg::CH_ZERO) && (a_char <= tacp_pkg::CH_NINE);
    dig      = is_digit ? a_char[3:0] : 4'd0;
    frac_dig = (kind_eff == tacp_pkg::KIND_DEC64) && seen_point;
    if (kind_eff == tacp_pkg::KIND_DEC64) begin
      expo = frac_dig ? rem_eff - 5'd1 : rem_eff;
    end else begin
      expo = '0;
    end
    pw   = tacp_pkg::pow10(expo);
    term = {64'd0, dig} * {4'd0, pw};
    base = frac_dig ? {5'd0, acc} : ({2'd0, acc, 3'd0} + {4'd0, acc, 1'd0});
    sum  = base + {1'b0, term};
    push_ovf = (|sum[68:64]) || ((dig != 4'd0) && (expo >= tacp_pkg::POW10_TOP));

    acc_next        = acc;
    rem_next        = rem_eff;
    pos_next        = (pos != tacp_pkg::POS_MAX) ? pos + 5'd1 : pos;
    seen_point_next = seen_point;
    any_digit_next  = any_digit;
    negative_next   = negative;
    failed_next     = failed;
    push            = 1'b0;

    unique case (kind_eff)
      tacp_pkg::KIND_INT32, tacp_pkg::KIND_INT64: begin
        if (pos == '0 && a_char == tacp_pkg::CH_MINUS) begin
          negative_next = 1'b1;
        end else if (is_digit) begin
          push           = 1'b1;
          any_digit_next = 1'b1;
        end else begin
          failed_next = 1'b1;
        end
      end
      tacp_pkg::KIND_DATE: begin
        if (pos >= tacp_pkg::DATE_LEN) begin
          failed_next = 1'b1;
        end else if (pos == tacp_pkg::DATE_SEP_A || pos == tacp_pkg::DATE_SEP_B) begin
          if (a_char != tacp_pkg::CH_MINUS) begin
            failed_next = 1'b1;
          end
        end else if (is_digit) begin
          push = 1'b1;
        end else begin
          failed_next = 1'b1;
        end
      end
      tacp_pkg::KIND_DEC64: begin
        if (pos == '0 && (a_char == tacp_pkg::CH_MINUS || a_char == tacp_pkg::CH_PLUS)) begin
          negative_next = (a_char == tacp_pkg::CH_MINUS);
        end else if (a_char == tacp_pkg::CH_POINT) begin
          if (seen_point) begin
            failed_next = 1'b1;
          end
          seen_point_next = 1'b1;
        end else if (is_digit) begin
          push           = 1'b1;
          any_digit_next = 1'b1;
          if (seen_point) begin
            if (rem_eff == '0) begin
              failed_next = 1'b1;
            end else begin
              rem_next = rem_eff - 5'd1;
            end
          end
        end else begin
          failed_next = 1'b1;
        end
      end
    endcase

    if (push) begin
      if (push_ovf) begin
        failed_next = 1'b1;
      end else begin
        acc_next = sum[63:0];
      end
    end

    fin_fail = failed_next
             || ((kind_eff != tacp_pkg::KIND_DATE) && !any_digit_next)
             || ((kind_eff == tacp_pkg::KIND_DATE) && (pos_next != tacp_pkg::DATE_LEN));
  end

  always_comb begin
    if (b_wide) begin
      lim = b_neg ? tacp_pkg::LIM_I64_NEG : tacp_pkg::LIM_I64_POS;
    end else begin
      lim = b_neg ? tacp_pkg::LIM_I32_NEG : tacp_pkg::LIM_I32_POS;
    end
    ok_calc = !b_fail && (b_acc <= lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      o_valid    <= 1'b0;
      acc        <= '0;
      rem        <= '0;
      pos        <= '0;
      seen_point <= 1'b0;
      any_digit  <= 1'b0;
      negative   <= 1'b0;
      failed     <= 1'b0;
      held_kind  <= '0;
    end else begin
      if (chars.ready) begin
        a_valid <= chars.valid;
      end
      if (b_free) begin
        b_valid <= a_adv && a_res;
      end
      if (o_free) begin
        o_valid <= b_valid;
      end
      if (a_adv) begin
        held_kind <= kind_eff;
        if (a_res) begin
          acc        <= '0;
          rem        <= '0;
          pos        <= '0;
          seen_point <= 1'b0;
          any_digit  <= 1'b0;
          negative   <= 1'b0;
          failed     <= 1'b0;
        end else begin
          acc        <= acc_next;
          rem        <= rem_next;
          pos        <= pos_next;
          seen_point <= seen_point_next;
          any_digit  <= any_digit_next;
          negative   <= negative_next;
          failed     <= failed_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      a_char  <= chars.char_byte;
      a_kind  <= chars.kind;
      a_scale <= chars.scale;
      a_last  <= chars.last;
      a_empty <= chars.empty_req;
    end
    if (a_adv && a_res) begin
      b_acc  <= a_empty ? 64'd0 : acc_next;
      b_neg  <= !a_empty && negative_next;
      b_fail <= a_empty || fin_fail;
      b_wide <= (kind_eff != tacp_pkg::KIND_INT32);
    end
    if (b_adv) begin
      o_ok <= ok_calc;
      if (!ok_calc) begin
        o_value <= '0;
      end else if (b_neg) begin
        o_value <= $signed(~b_acc + 64'd1);
      end else begin
        o_value <= $signed(b_acc);
      end
    end
  end

endmodule
